FILE: hdl/assert_macros.svh
// assertion macros shared by the maze search rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define GMD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define GMD_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GMD_ASSERT(lbl, clk, rst, prop, msg)
`define GMD_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

FILE: hdl/gmd_pkg.sv
// types and constants of the maze depth-first path search
package gmd_pkg;

   localparam int COORD_W = 3;
   localparam int DIR_W   = 3;
   localparam int ORD_W   = 7;
   localparam int MARK_W  = 2;
   localparam int CSR_IDX_W = 3;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [DIR_W-1:0]   dir_type;
   typedef logic [ORD_W-1:0]   ord_type;
   typedef logic [MARK_W-1:0]  mark_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // cell marks
   localparam mark_type MARK_WALL = 2'd0;
   localparam mark_type MARK_OPEN = 2'd1;
   localparam mark_type MARK_FOOT = 2'd2;
   localparam mark_type MARK_DEAD = 2'd3;

   // search directions, tried in this order
   localparam dir_type DIR_DOWN  = 3'd1;
   localparam dir_type DIR_LEFT  = 3'd2;
   localparam dir_type DIR_UP    = 3'd3;
   localparam dir_type DIR_RIGHT = 3'd4;

   // request functions
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_RUN  = 1'b1;

   // register indexes
   localparam csr_idx_type CSR_START_ROW = 3'd0;
   localparam csr_idx_type CSR_START_COL = 3'd1;
   localparam csr_idx_type CSR_END_ROW   = 3'd2;
   localparam csr_idx_type CSR_END_COL   = 3'd3;

   // one stack entry
   typedef struct packed {
      coord_type row;
      coord_type col;
      dir_type   dir;
      ord_type   ord;
   } entry_type;

   // search end points
   typedef struct packed {
      coord_type start_row;
      coord_type start_col;
      coord_type end_row;
      coord_type end_col;
   } cfg_type;

endpackage

FILE: hdl/gmd_mark_ram.sv
// cell mark memory, every cell reads as a wall until written
module gmd_mark_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  gmd_pkg::mark_type  wdata,
   input  logic [AW-1:0]      raddr,
   output gmd_pkg::mark_type  rdata
);
   import gmd_pkg::*;

   mark_type          mem_ff [DEPTH];
   logic [DEPTH-1:0]  written_ff;
   mark_type          rd_mark_ff;
   logic              rd_written_ff;

   // storage array with registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_mark_ff <= mem_ff[raddr];
   end

   // written flags, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (we) begin
            written_ff[waddr] <= 1'b1;
         end
         rd_written_ff <= written_ff[raddr];
      end
   end

   assign rdata = rd_written_ff ? rd_mark_ff : MARK_WALL;

endmodule

FILE: hdl/gmd_stack_ram.sv
// path stack memory, one write and one registered read port
module gmd_stack_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  gmd_pkg::entry_type wdata,
   input  logic [AW-1:0]      raddr,
   output gmd_pkg::entry_type rdata
);
   import gmd_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_ff;

   // storage array with registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

FILE: hdl/gmd_search.sv
// search sequencer: cell loads, depth-first walk and path output
`include "assert_macros.svh"

module gmd_search #(
   parameter int GRID_SIDE   = 8,
   parameter int STACK_DEPTH = 64,
   parameter int CELL_AW     = 6,
   parameter int STK_AW      = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  gmd_pkg::coord_type  req_cell_row,
   input  gmd_pkg::coord_type  req_cell_col,
   input  logic                req_cell_open,
   input  gmd_pkg::cfg_type    cfg,
   output logic                mark_we,
   output logic [CELL_AW-1:0]  mark_waddr,
   output gmd_pkg::mark_type   mark_wdata,
   output logic [CELL_AW-1:0]  mark_raddr,
   input  gmd_pkg::mark_type   mark_rdata,
   output logic                stk_we,
   output logic [STK_AW-1:0]   stk_waddr,
   output gmd_pkg::entry_type  stk_wdata,
   output logic [STK_AW-1:0]   stk_raddr,
   input  gmd_pkg::entry_type  stk_rdata,
   output logic                rsp_strobe,
   output gmd_pkg::ord_type    rsp_step_order,
   output gmd_pkg::coord_type  rsp_path_row,
   output gmd_pkg::coord_type  rsp_path_col,
   output logic                rsp_found,
   output logic                rsp_last
);
   import gmd_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(STACK_DEPTH);
   localparam logic [COORD_W:0]   SIDE      = (COORD_W + 1)'(GRID_SIDE);
   localparam coord_type          EDGE_HI   = COORD_W'(GRID_SIDE - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_POP   = 3'd3;
   localparam logic [2:0] S_ERD   = 3'd4;
   localparam logic [2:0] S_EOUT  = 3'd5;

   logic [2:0]        state_ff, state_in;
   coord_type         cur_row_ff, cur_row_in;
   coord_type         cur_col_ff, cur_col_in;
   logic              cur_off_ff, cur_off_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   ord_type           step_ff, step_in;
   logic [STK_AW-1:0] emit_idx_ff, emit_idx_in;
   logic              strobe_ff, strobe_in;
   ord_type           ord_ff, ord_in;
   coord_type         prow_ff, prow_in;
   coord_type         pcol_ff, pcol_in;
   logic              found_ff, found_in;
   logic              last_ff, last_in;

   logic [CNT_W-1:0]  cnt_m1;
   logic              passable;
   logic              at_goal;
   logic              fail_now;
   dir_type           next_dir;

   function automatic logic in_grid(coord_type r, coord_type c);
      return ({1'b0, r} < SIDE) && ({1'b0, c} < SIDE);
   endfunction

   function automatic logic [CELL_AW-1:0] cell_addr(coord_type r, coord_type c);
      return CELL_AW'(int'(r) * GRID_SIDE + int'(c));
   endfunction

   // neighbour in a direction, with a flag for leaving the grid
   function automatic logic [2*COORD_W:0] step_cell(coord_type r, coord_type c,
                                                   dir_type d);
      coord_type nr;
      coord_type nc;
      logic      off;
      nr  = r;
      nc  = c;
      off = 1'b0;
      case (d)
         DIR_DOWN: begin
            nr  = r + 1'b1;
            off = (r == EDGE_HI);
         end
         DIR_LEFT: begin
            nc  = c - 1'b1;
            off = (c == '0);
         end
         DIR_UP: begin
            nr  = r - 1'b1;
            off = (r == '0);
         end
         default: begin
            nc  = c + 1'b1;
            off = (c == EDGE_HI);
         end
      endcase
      return {off, nr, nc};
   endfunction

   assign cnt_m1   = cnt_ff - CNT_W'(1);
   assign passable = !cur_off_ff && (mark_rdata == MARK_OPEN);
   assign at_goal  = (cur_row_ff == cfg.end_row) && (cur_col_ff == cfg.end_col);
   assign next_dir = stk_rdata.dir + 1'b1;

   // sequencer next state and memory port control
   always_comb begin
      state_in    = state_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      cur_off_in  = cur_off_ff;
      cnt_in      = cnt_ff;
      step_in     = step_ff;
      emit_idx_in = emit_idx_ff;
      strobe_in   = 1'b0;
      ord_in      = ord_ff;
      prow_in     = prow_ff;
      pcol_in     = pcol_ff;
      found_in    = found_ff;
      last_in     = last_ff;
      fail_now    = 1'b0;

      mark_we       = 1'b0;
      mark_waddr    = cell_addr(cur_row_ff, cur_col_ff);
      mark_wdata    = MARK_FOOT;
      mark_raddr    = cell_addr(cur_row_ff, cur_col_ff);
      stk_we        = 1'b0;
      stk_waddr     = cnt_ff[STK_AW-1:0];
      stk_wdata.row = cur_row_ff;
      stk_wdata.col = cur_col_ff;
      stk_wdata.dir = DIR_DOWN;
      stk_wdata.ord = step_ff;
      stk_raddr     = cnt_m1[STK_AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_func == FUNC_LOAD) begin
                  mark_we    = in_grid(req_cell_row, req_cell_col);
                  mark_waddr = cell_addr(req_cell_row, req_cell_col);
                  mark_wdata = req_cell_open ? MARK_OPEN : MARK_WALL;
               end else begin
                  cur_row_in = cfg.start_row;
                  cur_col_in = cfg.start_col;
                  cur_off_in = !in_grid(cfg.start_row, cfg.start_col);
                  cnt_in     = '0;
                  step_in    = ORD_W'(1);
                  state_in   = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (passable) begin
               // enter the cell: footprint, then push unless the stack is full
               mark_we = 1'b1;
               if (cnt_ff == DEPTH_CNT) begin
                  fail_now = 1'b1;
               end else begin
                  stk_we = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
                  if (at_goal) begin
                     emit_idx_in = cnt_ff[STK_AW-1:0];
                     state_in    = S_ERD;
                  end else begin
                     {cur_off_in, cur_row_in, cur_col_in} =
                        step_cell(cur_row_ff, cur_col_ff, DIR_DOWN);
                     step_in  = step_ff + ORD_W'(1);
                     state_in = S_LOOK;
                  end
               end
            end else if (cnt_ff != '0) begin
               cnt_in   = cnt_m1;
               state_in = S_POP;
            end else begin
               fail_now = 1'b1;
            end
         end
         S_POP: begin
            if ((stk_rdata.dir == DIR_RIGHT) && (cnt_ff != '0)) begin
               // exhausted cell: mark dead and pop the one below
               mark_we    = 1'b1;
               mark_waddr = cell_addr(stk_rdata.row, stk_rdata.col);
               mark_wdata = MARK_DEAD;
               cnt_in     = cnt_m1;
            end else if (stk_rdata.dir != DIR_RIGHT) begin
               // try the next direction from this cell
               stk_we        = 1'b1;
               stk_wdata     = stk_rdata;
               stk_wdata.dir = next_dir;
               cnt_in        = cnt_ff + CNT_W'(1);
               {cur_off_in, cur_row_in, cur_col_in} =
                  step_cell(stk_rdata.row, stk_rdata.col, next_dir);
               state_in = S_LOOK;
            end else begin
               fail_now = 1'b1;
            end
         end
         S_ERD: begin
            stk_raddr = emit_idx_ff;
            state_in  = S_EOUT;
         end
         S_EOUT: begin
            strobe_in = 1'b1;
            ord_in    = stk_rdata.ord;
            prow_in   = stk_rdata.row;
            pcol_in   = stk_rdata.col;
            found_in  = 1'b1;
            last_in   = (emit_idx_ff == '0);
            if (emit_idx_ff == '0) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               emit_idx_in = emit_idx_ff - 1'b1;
               state_in    = S_ERD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // failed search gives a single word with found clear
      if (fail_now) begin
         strobe_in = 1'b1;
         ord_in    = '0;
         prow_in   = '0;
         pcol_in   = '0;
         found_in  = 1'b0;
         last_in   = 1'b1;
         cnt_in    = '0;
         state_in  = S_IDLE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         step_ff   <= ORD_W'(1);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         step_ff   <= step_in;
         strobe_ff <= strobe_in;
      end
   end

   // walk position and result word
   always_ff @(posedge clock) begin
      cur_row_ff  <= cur_row_in;
      cur_col_ff  <= cur_col_in;
      cur_off_ff  <= cur_off_in;
      emit_idx_ff <= emit_idx_in;
      ord_ff      <= ord_in;
      prow_ff     <= prow_in;
      pcol_ff     <= pcol_in;
      found_ff    <= found_in;
      last_ff     <= last_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_step_order = ord_ff;
   assign rsp_path_row   = prow_ff;
   assign rsp_path_col   = pcol_ff;
   assign rsp_found      = found_ff;
   assign rsp_last       = last_ff;

   // checks
   `GMD_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= DEPTH_CNT, "stack count past depth")
   `GMD_ASSERT(a_word_from_run, clock, reset, strobe_ff |-> $past(state_ff != S_IDLE), "result word without a run")
   `GMD_ASSERT(a_last_ends_run, clock, reset, (strobe_ff && last_ff) |-> (state_ff == S_IDLE), "run still going after last word")
   `GMD_NEVER(a_no_mark_in_emit, clock, reset, mark_we && ((state_ff == S_ERD) || (state_ff == S_EOUT)), "cell mark written while sending the path")

endmodule

FILE: hdl/grid_maze_dfs_path.sv
// Maze path search top level: registers, mark memory, path stack, sequencer.
// Load word: accepted from idle with no result, and the block stays idle, ready for the next word.
// Run word: each cell probe passes S_LOOK then S_CHECK, each stack pop passes S_POP,
// and each path word sent passes S_ERD then S_EOUT.
// Results go out one per strobe and cannot be held off; busy is high throughout a run.
// Reset: synchronous; all cells read as walls at once, ends at (0,0) and (7,7).
module grid_maze_dfs_path #(
   parameter int GRID_SIDE   = 8,
   parameter int STACK_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_func,
   input  gmd_pkg::coord_type     req_cell_row,
   input  gmd_pkg::coord_type     req_cell_col,
   input  logic                   req_cell_open,
   output logic                   rsp_strobe,
   output gmd_pkg::ord_type       rsp_step_order,
   output gmd_pkg::coord_type     rsp_path_row,
   output gmd_pkg::coord_type     rsp_path_col,
   output logic                   rsp_found,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  gmd_pkg::csr_idx_type   csr_index,
   input  gmd_pkg::coord_type     csr_wdata
);
   import gmd_pkg::*;

   localparam int CELLS   = GRID_SIDE * GRID_SIDE;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int STK_AW  = $clog2(STACK_DEPTH);

   cfg_type             cfg_ff;
   logic                mark_we;
   logic [CELL_AW-1:0]  mark_waddr;
   mark_type            mark_wdata;
   logic [CELL_AW-1:0]  mark_raddr;
   mark_type            mark_rdata;
   logic                stk_we;
   logic [STK_AW-1:0]   stk_waddr;
   entry_type           stk_wdata;
   logic [STK_AW-1:0]   stk_raddr;
   entry_type           stk_rdata;

   // search end point registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_row <= 3'd0;
         cfg_ff.start_col <= 3'd0;
         cfg_ff.end_row   <= 3'd7;
         cfg_ff.end_col   <= 3'd7;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_ROW: cfg_ff.start_row <= csr_wdata;
            CSR_START_COL: cfg_ff.start_col <= csr_wdata;
            CSR_END_ROW:   cfg_ff.end_row   <= csr_wdata;
            CSR_END_COL:   cfg_ff.end_col   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // cell marks
   gmd_mark_ram #(
      .DEPTH (CELLS),
      .AW    (CELL_AW)
   ) u_mark_ram (
      .clock (clock),
      .reset (reset),
      .we    (mark_we),
      .waddr (mark_waddr),
      .wdata (mark_wdata),
      .raddr (mark_raddr),
      .rdata (mark_rdata)
   );

   // path stack
   gmd_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .AW    (STK_AW)
   ) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // sequencer
   gmd_search #(
      .GRID_SIDE   (GRID_SIDE),
      .STACK_DEPTH (STACK_DEPTH),
      .CELL_AW     (CELL_AW),
      .STK_AW      (STK_AW)
   ) u_search (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_cell_row   (req_cell_row),
      .req_cell_col   (req_cell_col),
      .req_cell_open  (req_cell_open),
      .cfg            (cfg_ff),
      .mark_we        (mark_we),
      .mark_waddr     (mark_waddr),
      .mark_wdata     (mark_wdata),
      .mark_raddr     (mark_raddr),
      .mark_rdata     (mark_rdata),
      .stk_we         (stk_we),
      .stk_waddr      (stk_waddr),
      .stk_wdata      (stk_wdata),
      .stk_raddr      (stk_raddr),
      .stk_rdata      (stk_rdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_step_order (rsp_step_order),
      .rsp_path_row   (rsp_path_row),
      .rsp_path_col   (rsp_path_col),
      .rsp_found      (rsp_found),
      .rsp_last       (rsp_last)
   );

endmodule
